// ===== hdl/sks_pkg.sv =====
// Shared types and constants of the SHA-1 shard key selector.
// No dependencies; every other file imports this package.
package sks_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgShardMask  = 2'd0,
    CfgNewIdMask  = 2'd1,
    CfgShardCount = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] SHARD_MASK_RST  = 32'd127;
  localparam logic [63:0] NEW_ID_MASK_RST = 64'd128;
  localparam logic [31:0] SHARD_COUNT_RST = 32'd64;

  // SHA-1 initial chaining words and round constants
  localparam logic [31:0] H0_INIT = 32'h6745_2301;
  localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
  localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
  localparam logic [31:0] H3_INIT = 32'h1032_5476;
  localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;
  localparam logic [31:0] K_R0 = 32'h5A82_7999;
  localparam logic [31:0] K_R1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_R3 = 32'hCA62_C1D6;

  // Padding words of the single 8-byte message block
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] LEN_WORD = 32'd64;

  localparam logic [31:0] USER_SHARD_FLAG = 32'd64;

  // One result beat
  typedef struct packed {
    logic [31:0] order_shard;
    logic [9:0]  order_server;
    logic [13:0] order_counter;
    logic [31:0] order_timestamp;
    logic        order_is_new;
    logic [31:0] shop_shard;
    logic [31:0] user_shard;
  } key_t;

endpackage

// ===== hdl/sks_if.sv =====
// Valid/ready channel interfaces of the shard key selector.
// Depends on sks_pkg for the result beat type.
interface sks_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] id_value;
  modport source (output valid, output id_value, input ready);
  modport sink   (input valid, input id_value, output ready);
endinterface

interface sks_out_if import sks_pkg::*; ;
  logic valid;
  logic ready;
  key_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sks_sha1.sv =====
// Eighty-stage SHA-1 round pipeline over one padded 8-byte block; yields H0.
// Depends on sks_pkg for the initial words and round constants.
module sks_sha1 import sks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        vld_i,
  input  logic [63:0] id_i,
  output logic        vld_o,
  output logic [31:0] h0_o,
  output logic [63:0] id_o
);

  localparam int Rounds = 80;

  typedef struct packed {
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
    logic [31:0]       e;
    logic [15:0][31:0] w;
    logic [63:0]       id;
  } st_t;

  // One compression round plus one step of the message schedule window
  function automatic st_t sha_round(st_t s, logic [6:0] t);
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] x;
    st_t         r;
    if (t < 7'd20) begin
      f = (s.b & s.c) | (~s.b & s.d);
      k = K_R0;
    end else if (t < 7'd40) begin
      f = s.b ^ s.c ^ s.d;
      k = K_R1;
    end else if (t < 7'd60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
      k = K_R2;
    end else begin
      f = s.b ^ s.c ^ s.d;
      k = K_R3;
    end
    x    = s.w[13] ^ s.w[8] ^ s.w[2] ^ s.w[0];
    r.id = s.id;
    r.a  = {s.a[26:0], s.a[31:27]} + f + s.e + k + s.w[0];
    r.b  = s.a;
    r.c  = {s.b[1:0], s.b[31:2]};
    r.d  = s.c;
    r.e  = s.d;
    r.w  = {{x[30:0], x[31]}, s.w[15:1]};
    return r;
  endfunction

  st_t  st_in;
  st_t  st_q  [Rounds];
  logic vld_q [Rounds];

  // Load the padded block and the initial chaining words
  always_comb begin
    st_in      = '0;
    st_in.a    = H0_INIT;
    st_in.b    = H1_INIT;
    st_in.c    = H2_INIT;
    st_in.d    = H3_INIT;
    st_in.e    = H4_INIT;
    st_in.w[0] = id_i[63:32];
    st_in.w[1] = id_i[31:0];
    st_in.w[2] = PAD_WORD;
    st_in.w[15] = LEN_WORD;
    st_in.id   = id_i;
  end

  for (genvar t = 0; t < Rounds; t++) begin : g_round
    st_t  prv;
    logic prv_vld;
    if (t == 0) begin : g_first
      assign prv     = st_in;
      assign prv_vld = vld_i;
    end else begin : g_next
      assign prv     = st_q[t-1];
      assign prv_vld = vld_q[t-1];
    end

    // Advance the valid bit with the pipeline
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[t] <= 1'b0;
      end else if (adv_i) begin
        vld_q[t] <= prv_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[t] <= sha_round(prv, 7'(t));
      end
    end
  end

  assign vld_o = vld_q[Rounds-1];
  assign h0_o  = H0_INIT + st_q[Rounds-1].a;
  assign id_o  = st_q[Rounds-1].id;

endmodule

// ===== hdl/sks_mod.sv =====
// Two-lane restoring remainder pipeline, one quotient bit per stage. Uses
// sks_pkg by convention; user holds divisor static while busy, unchecked.
module sks_mod import sks_pkg::*; #(
  parameter int PayW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  logic [31:0]     xa_i,
  input  logic [31:0]     xb_i,
  input  logic [31:0]     n_i,
  input  logic [PayW-1:0] pay_i,
  output logic            vld_o,
  output logic [31:0]     ra_o,
  output logic [31:0]     rb_o,
  output logic [PayW-1:0] pay_o
);

  localparam int Steps = 32;

  typedef struct packed {
    logic [31:0]     ra;
    logic [31:0]     xa;
    logic [31:0]     rb;
    logic [31:0]     xb;
    logic [PayW-1:0] pay;
  } st_t;

  // Shift in one dividend bit and subtract the divisor when it fits.
  // A zero divisor always fits, so the dividend passes through unchanged.
  function automatic logic [31:0] rem_step(logic [31:0] r, logic b, logic [31:0] n);
    logic [32:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[31:0];
  endfunction

  st_t  st_in;
  st_t  st_q  [Steps];
  logic vld_q [Steps];

  assign st_in = '{ra: '0, xa: xa_i, rb: '0, xb: xb_i, pay: pay_i};

  for (genvar j = 0; j < Steps; j++) begin : g_step
    st_t  prv;
    logic prv_vld;
    if (j == 0) begin : g_first
      assign prv     = st_in;
      assign prv_vld = vld_i;
    end else begin : g_next
      assign prv     = st_q[j-1];
      assign prv_vld = vld_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv_i) begin
        vld_q[j] <= prv_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[j].ra  <= rem_step(prv.ra, prv.xa[31], n_i);
        st_q[j].xa  <= {prv.xa[30:0], 1'b0};
        st_q[j].rb  <= rem_step(prv.rb, prv.xb[31], n_i);
        st_q[j].xb  <= {prv.xb[30:0], 1'b0};
        st_q[j].pay <= prv.pay;
      end
    end
  end

  assign vld_o = vld_q[Steps-1];
  assign ra_o  = st_q[Steps-1].ra;
  assign rb_o  = st_q[Steps-1].rb;
  assign pay_o = st_q[Steps-1].pay;

endmodule

// ===== hdl/sha1_shard_key_selector_top.sv =====
// Shard key selector: takes one 64-bit identifier per beat and returns its
// order fields plus SHA-1 (word H0) based shop and user shard numbers. One
// identifier is taken every cycle while the output is not stalled; each result
// passes 80 SHA-1 round stages, 32 remainder stages and one output register. A stalled
// output freezes the whole pipeline in place, so nothing is lost or repeated.
// Configuration writes are to be made only while the pipeline is empty.
// Depends on sks_pkg, sks_if, sks_sha1 and sks_mod.
module sha1_shard_key_selector_top import sks_pkg::*; #(
  parameter int SHARD_BITS   = 7,
  parameter int SERVER_BITS  = 10,
  parameter int COUNTER_BITS = 14,
  parameter int TIME_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  sks_in_if.sink      id_in,
  sks_out_if.source   key_out
);

  localparam int ServPos = SHARD_BITS + 1;
  localparam int CntPos  = ServPos + SERVER_BITS;
  localparam int TimePos = CntPos + COUNTER_BITS;

  // Field at pos, width bits wide; a field starting past bit 63 reads zero
  function automatic logic [63:0] take_field(logic [63:0] v, int pos, int width);
    logic [63:0] m;
    if (pos >= 64) begin
      return '0;
    end
    m = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    return (v >> pos) & m;
  endfunction

  logic [31:0] shard_mask_q;
  logic [63:0] new_id_mask_q;
  logic [31:0] shard_count_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shard_mask_q  <= SHARD_MASK_RST;
      new_id_mask_q <= NEW_ID_MASK_RST;
      shard_count_q <= SHARD_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgShardMask:  shard_mask_q  <= cfg_data_i[31:0];
        CfgNewIdMask:  new_id_mask_q <= cfg_data_i;
        CfgShardCount: shard_count_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic        adv;
  logic        out_vld_q;
  key_t        key_q;
  logic        sha_vld;
  logic [31:0] sha_h0;
  logic [63:0] sha_id;
  logic        mod_vld;
  logic [31:0] mod_shop;
  logic [31:0] mod_user;
  logic [63:0] mod_id;

  // Move every stage when the output register is empty or being drained
  assign adv          = !out_vld_q || key_out.ready;
  assign id_in.ready  = adv;

  sks_sha1 u_sha1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (id_in.valid),
    .id_i   (id_in.id_value),
    .vld_o  (sha_vld),
    .h0_o   (sha_h0),
    .id_o   (sha_id)
  );

  sks_mod #(.PayW(64)) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (sha_vld),
    .xa_i   (sha_h0),
    .xb_i   (sha_h0 & shard_mask_q),
    .n_i    (shard_count_q),
    .pay_i  (sha_id),
    .vld_o  (mod_vld),
    .ra_o   (mod_shop),
    .rb_o   (mod_user),
    .pay_o  (mod_id)
  );

  // Output register: unpack order fields and attach shard numbers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mod_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      key_q.order_shard     <= mod_id[31:0] & shard_mask_q;
      key_q.order_server    <= 10'(take_field(mod_id, ServPos, SERVER_BITS));
      key_q.order_counter   <= 14'(take_field(mod_id, CntPos, COUNTER_BITS));
      key_q.order_timestamp <= 32'(take_field(mod_id, TimePos, TIME_BITS));
      key_q.order_is_new    <= (mod_id & new_id_mask_q) == new_id_mask_q;
      key_q.shop_shard      <= mod_shop;
      key_q.user_shard      <= mod_user | USER_SHARD_FLAG;
    end
  end

  assign key_out.valid = out_vld_q;
  assign key_out.data  = key_q;

  // A held result blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !key_out.ready |-> !id_in.ready)
    else $error("input taken while result is stalled");

  a_shop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && shard_count_q != '0 |-> key_q.shop_shard < shard_count_q)
    else $error("shop shard not below shard count");

  a_user_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (key_q.user_shard & USER_SHARD_FLAG) == USER_SHARD_FLAG)
    else $error("user shard flag missing");

  a_shard_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (key_q.order_shard & ~shard_mask_q) == '0)
    else $error("order shard has bits outside mask");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the SHA-1 shard key selector.
// Depends on sks_pkg, sks_if and the RTL top sha1_shard_key_selector_top.
module tb_top import sks_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT   = 113;
  localparam int N_RANDOM   = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POS_SERVER  = 8;
  localparam int POS_COUNTER = 18;
  localparam int POS_TIME    = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  sks_in_if  id_ch ();
  sks_out_if key_ch ();

  sha1_shard_key_selector_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .id_in     (id_ch.sink),
    .key_out   (key_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the registers
  logic [31:0] mask_q  = SHARD_MASK_RST;
  logic [63:0] newid_q = NEW_ID_MASK_RST;
  logic [31:0] count_q = SHARD_COUNT_RST;

  key_t keys_pending[$];
  int   n_mismatch = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // First digest word of SHA-1 over the eight identifier bytes
  function automatic logic [31:0] digest_h0(logic [63:0] id);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    a = 32'h67452301; b = 32'hEFCDAB89; c = 32'h98BADCFE;
    d = 32'h10325476; e = 32'hC3D2E1F0;
    for (int i = 0; i < 16; i++) w[i] = '0;
    w[0] = id[63:32];
    w[1] = id[31:0];
    w[2] = 32'h80000000;
    w[15] = 32'd64;
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return 32'h67452301 + a;
  endfunction

  function automatic logic [31:0] rem_or_pass(logic [31:0] x, logic [31:0] n);
    return (n == 0) ? x : x % n;
  endfunction

  function automatic key_t shard_keys(logic [63:0] id);
    key_t r;
    logic [31:0] h;
    h = digest_h0(id);
    r.order_shard     = id[31:0] & mask_q;
    r.order_server    = id[POS_SERVER +: 10];
    r.order_counter   = id[POS_COUNTER +: 14];
    r.order_timestamp = id[POS_TIME +: 32];
    r.order_is_new    = ((id & newid_q) == newid_q);
    r.shop_shard      = rem_or_pass(h, count_q);
    r.user_shard      = rem_or_pass(h & mask_q, count_q) | 32'd64;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    n_mismatch++;
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
  endtask

  // Drop valid for a random stretch; a zero-length gap keeps beats back to back
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 1) == 0) n = 0;
    if (n != 0) begin
      id_ch.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Offer one beat and hold it until taken; valid stays up for the next beat
  task automatic send_id(logic [63:0] id);
    id_ch.valid    <= 1'b1;
    id_ch.id_value <= id;
    do @(posedge clk_i); while (!id_ch.ready);
    keys_pending.push_back(shard_keys(id));
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgShardMask:  mask_q  = val[31:0];
      CfgNewIdMask:  newid_q = val;
      CfgShardCount: count_q = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    id_ch.valid <= 1'b0;
    while (keys_pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 5) @(negedge clk_i);
  endtask

  // Directed rows: identifier plus an optional typed-in order field check
  typedef struct {
    logic [63:0] id;
    bit          has_exp;
    logic [31:0] exp_shard;
    logic        exp_new;
  } row_t;

  row_t rows[$];

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    key_t got, want;
    if (rst_ni && key_ch.valid && key_ch.ready) begin
      got = key_ch.data;
      if (keys_pending.size() == 0) begin
        report("unexpected beat", got.shop_shard, 0);
      end else begin
        want = keys_pending.pop_front();
        if (got.order_shard !== want.order_shard)
          report("order_shard", got.order_shard, want.order_shard);
        if (got.order_server !== want.order_server)
          report("order_server", got.order_server, want.order_server);
        if (got.order_counter !== want.order_counter)
          report("order_counter", got.order_counter, want.order_counter);
        if (got.order_timestamp !== want.order_timestamp)
          report("order_timestamp", got.order_timestamp, want.order_timestamp);
        if (got.order_is_new !== want.order_is_new)
          report("order_is_new", got.order_is_new, want.order_is_new);
        if (got.shop_shard !== want.shop_shard)
          report("shop_shard", got.shop_shard, want.shop_shard);
        if (got.user_shard !== want.user_shard)
          report("user_shard", got.user_shard, want.user_shard);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    key_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        key_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        key_ch.ready <= 1'b0;
        if ($urandom_range(0, 15) == 0) repeat ($urandom_range(5, 40)) @(negedge clk_i);
      end else begin
        key_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [63:0] id;
    id_ch.valid    = 1'b0;
    id_ch.id_value = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: order_shard masked by 127, new flag is bit 7
    rows = '{
      '{64'h0, 1'b1, 32'h0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h7F, 1'b1},
      '{64'h80, 1'b1, 32'h0, 1'b1},
      '{64'h7F, 1'b1, 32'h7F, 1'b0},
      '{64'h8000_0000_0000_0000, 1'b0, 32'h0, 1'b0},
      '{64'h0000_0000_FFFF_FF00, 1'b0, 32'h0, 1'b0},
      '{64'hFFFF_FFFF_0000_0000, 1'b0, 32'h0, 1'b0},
      '{64'h0123_4567_89AB_CDEF, 1'b0, 32'h0, 1'b0}
    };
    foreach (rows[i]) begin
      send_id(rows[i].id);
      // Hold the typed-in order fields against the result itself
      if (rows[i].has_exp) begin
        keys_pending[$].order_shard  = rows[i].exp_shard;
        keys_pending[$].order_is_new = rows[i].exp_new;
      end
    end
    drain();

    // Extremes: empty and full masks, and shard counts of zero, one and all ones
    write_reg(CfgShardMask, 64'h0);
    write_reg(CfgNewIdMask, 64'h0);
    write_reg(CfgShardCount, 64'h0);
    send_id(64'h0);
    send_id(64'hFFFF_FFFF_FFFF_FFFF);
    send_id(64'hDEAD_BEEF_0BAD_F00D);
    drain();
    write_reg(CfgShardMask, 64'hFFFF_FFFF);
    write_reg(CfgNewIdMask, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgShardCount, 64'h1);
    send_id(64'hFFFF_FFFF_FFFF_FFFF);
    send_id(64'hFFFF_FFFF_FFFF_FFFE);
    drain();
    write_reg(CfgShardCount, 64'hFFFF_FFFF);
    send_id(64'h5555_5555_AAAA_AAAA);
    send_id(64'hAAAA_AAAA_5555_5555);
    drain();

    // Random phases, each with a fresh register setting
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgShardMask, ph == 0 ? 64'h7F : {32'h0, $urandom()});
      write_reg(CfgNewIdMask, ph == 0 ? 64'h80 : 64'h1 << $urandom_range(0, 63));
      write_reg(CfgShardCount, ph == 0 ? 64'd64 :
                (ph == 4 ? {32'h0, $urandom()} : $urandom_range(0, 300)));
      if (ph == 2) hold_off = 1'b1;
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        id = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) == 0) id = id | newid_q;
        send_id(id);
        if (ph != 2) idle_gap();
      end
      drain();
    end

    if (n_mismatch == 0 && keys_pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sks_pkg.sv
hdl/sks_if.sv
hdl/sks_sha1.sv
hdl/sks_mod.sv
hdl/sha1_shard_key_selector_top.sv
sim/tb_top.sv
